### design/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// shared types, status codes and the status length table for the midi byte
// stream parser
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RT_ON  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_ON = 1'b1;

    localparam logic [BYTE_W-1:0] ST_PROG_CHANGE = 8'hC0;
    localparam logic [BYTE_W-1:0] ST_PITCH_BEND  = 8'hE0;
    localparam logic [BYTE_W-1:0] ST_SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_MTC_QFRAME  = 8'hF1;
    localparam logic [BYTE_W-1:0] ST_SONG_POS    = 8'hF2;
    localparam logic [BYTE_W-1:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [BYTE_W-1:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [BYTE_W-1:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [BYTE_W-1:0] ST_RT_FIRST    = 8'hF8;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TWO   = 2'd1,
        MODE_THREE = 2'd2,
        MODE_SYSEX = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        LEN_NONE  = 2'd0,
        LEN_ONE   = 2'd1,
        LEN_TWO   = 2'd2,
        LEN_THREE = 2'd3
    } len_t;

    typedef enum logic {
        KIND_REALTIME = 1'b0,
        KIND_DEFAULT  = 1'b1
    } kind_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } beat_t;

    typedef struct packed {
        kind_t             kind;
        logic [1:0]        count;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] third;
    } result_t;

    function automatic len_t status_len(input logic [BYTE_W-1:0] b);
        len_t len;
        if (b < ST_PROG_CHANGE)
        begin
            len = LEN_THREE;
        end
        else if (b < ST_PITCH_BEND)
        begin
            len = LEN_TWO;
        end
        else if (b < ST_SYSEX_START)
        begin
            len = LEN_THREE;
        end
        else
        begin
            case (b) inside
                ST_MTC_QFRAME, ST_SONG_SEL: len = LEN_TWO;
                ST_SONG_POS:                len = LEN_THREE;
                ST_TUNE_REQ:                len = LEN_ONE;
                default:                    len = (b >= ST_RT_FIRST) ? LEN_ONE : LEN_NONE;
            endcase
        end
        return len;
    endfunction

endpackage

### design/mbsp_in_stage.sv
// ----------------------------------------------------------------------------
// mbsp_in_stage
// input register: holds one byte until the parser can take it
// ----------------------------------------------------------------------------
module mbsp_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mbsp_pkg::BYTE_W-1:0] midi_byte,
    input  logic                        can_advance,
    output mbsp_pkg::beat_t             beat,
    output logic                        advance
);
    import mbsp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    assign in_stall = valid_reg && !can_advance;
    assign advance  = valid_reg && can_advance;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                data_next = midi_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

### design/mbsp_parse.sv
// ----------------------------------------------------------------------------
// mbsp_parse
// parse state, handler enables and the single-pass decode of one byte
// ----------------------------------------------------------------------------
module mbsp_parse (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [mbsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    input  mbsp_pkg::beat_t                beat,
    input  logic                           advance,
    output logic                           res_valid,
    output mbsp_pkg::result_t              res
);
    import mbsp_pkg::*;

    logic                   rt_on_reg;
    logic                   def_on_reg;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [1:0]             count_reg;
    logic [1:0]             count_next;
    logic [2:0][BYTE_W-1:0] held_reg;
    logic [2:0][BYTE_W-1:0] held_next;

    logic [BYTE_W-1:0]      b;
    logic [2:0][BYTE_W-1:0] w_held;
    logic [1:0]             w_cnt;
    logic [1:0]             c_clamp;
    logic [1:0]             c_inc;
    logic                   emit;
    logic [1:0]             e_cnt;
    logic [2:0][BYTE_W-1:0] e_bytes;
    logic                   rt_kind;

    assign b = beat.data;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        held_next  = held_reg;
        emit       = 1'b0;
        e_cnt      = 2'd1;
        e_bytes    = {{(2*BYTE_W){1'b0}}, b};
        w_held     = held_reg;
        w_cnt      = count_reg;
        c_clamp    = (count_reg == 2'd3) ? 2'd2 : count_reg;
        c_inc      = c_clamp + 2'd1;
        if (advance)
        begin
            if (b >= ST_RT_FIRST)
            begin
                emit = 1'b1;
            end
            else if (b[BYTE_W-1])
            begin
                if (mode_reg != MODE_SYSEX)
                begin
                    w_held[0] = b;
                    w_cnt     = 2'd1;
                end
                held_next  = w_held;
                count_next = w_cnt;
                unique case (status_len(b))
                    LEN_ONE:
                    begin
                        mode_next = MODE_IDLE;
                        emit      = 1'b1;
                    end
                    LEN_TWO:   mode_next = MODE_TWO;
                    LEN_THREE: mode_next = MODE_THREE;
                    LEN_NONE:
                    begin
                        if (b == ST_SYSEX_START)
                        begin
                            mode_next = MODE_SYSEX;
                        end
                        else if (b == ST_SYSEX_END)
                        begin
                            c_clamp           = (w_cnt == 2'd3) ? 2'd2 : w_cnt;
                            c_inc             = c_clamp + 2'd1;
                            w_held[c_clamp]   = b;
                            held_next         = w_held;
                            count_next        = c_inc;
                            mode_next         = MODE_IDLE;
                            emit              = 1'b1;
                            e_cnt             = c_inc;
                            e_bytes           = w_held;
                        end
                        else
                        begin
                            mode_next  = MODE_IDLE;
                            count_next = 2'd0;
                        end
                    end
                    default:   mode_next = MODE_IDLE;
                endcase
            end
            else if (mode_reg != MODE_IDLE)
            begin
                w_held[c_clamp] = b;
                held_next       = w_held;
                e_bytes         = w_held;
                if (c_inc == 2'd3)
                begin
                    if (mode_reg != MODE_SYSEX)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    count_next = 2'd0;
                    emit       = 1'b1;
                    e_cnt      = 2'd3;
                end
                else if (c_inc == 2'd2)
                begin
                    count_next = 2'd2;
                    if (mode_reg == MODE_TWO)
                    begin
                        mode_next = MODE_IDLE;
                        emit      = 1'b1;
                        e_cnt     = 2'd2;
                    end
                end
                else
                begin
                    count_next = c_inc;
                    if (mode_reg != MODE_SYSEX)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
        end
    end

    // a lone real-time byte goes to its own handler when that is on
    assign rt_kind   = (e_cnt == 2'd1) && (e_bytes[0] >= ST_RT_FIRST) && rt_on_reg;
    assign res_valid = emit && (rt_kind || def_on_reg);

    assign res.kind   = rt_kind ? KIND_REALTIME : KIND_DEFAULT;
    assign res.count  = e_cnt;
    assign res.first  = e_bytes[0];
    assign res.second = (e_cnt >= 2'd2) ? e_bytes[1] : {BYTE_W{1'b0}};
    assign res.third  = (e_cnt == 2'd3) ? e_bytes[2] : {BYTE_W{1'b0}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_on_reg  <= 1'b0;
            def_on_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            count_reg  <= 2'd0;
            held_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_RT_ON))
            begin
                rt_on_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_DEF_ON))
            begin
                def_on_reg <= cfg_data;
            end
            mode_reg  <= mode_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    a_res_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> advance && beat.valid)
        else $error("result produced without a byte in the input register");

    a_rt_kind_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == KIND_REALTIME) |-> (res.count == 2'd1) && (res.first >= ST_RT_FIRST))
        else $error("real-time result with wrong shape");

    a_rt_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (b >= ST_RT_FIRST) |=> $stable(mode_reg) && $stable(count_reg) && $stable(held_reg))
        else $error("real-time byte disturbed the parse state");

    a_idle_drops_data: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !b[BYTE_W-1] && (mode_reg == MODE_IDLE) |=> (mode_reg == MODE_IDLE) && $stable(count_reg))
        else $error("data byte while idle changed the parse state");

endmodule

### design/mbsp_out_stage.sv
// ----------------------------------------------------------------------------
// mbsp_out_stage
// result register: holds one result until the receiver takes it
// ----------------------------------------------------------------------------
module mbsp_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        res_valid,
    input  mbsp_pkg::result_t           res,
    output logic                        can_advance,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        result_kind,
    output logic [1:0]                  byte_count,
    output logic [mbsp_pkg::BYTE_W-1:0] first_byte,
    output logic [mbsp_pkg::BYTE_W-1:0] second_byte,
    output logic [mbsp_pkg::BYTE_W-1:0] third_byte
);
    import mbsp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;
    result_t data_next;

    assign can_advance = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (can_advance)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid   = valid_reg;
    assign result_kind = data_reg.kind;
    assign byte_count  = data_reg.count;
    assign first_byte  = data_reg.first;
    assign second_byte = data_reg.second;
    assign third_byte  = data_reg.third;

endmodule

### design/midi_byte_stream_parser_core.sv
// path: a byte passes through the input register and then the result register on its way to out_valid
// throughput: one byte per cycle while out_stall does not hold the result register, set by the
//   single decode pass between the input register and the result register
// reset: asynchronous, clears the parse mode, held bytes and count, both
//   handler enables and both stage valids
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core
// assembles midi messages and sysex chunks from a stream of raw bytes
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mbsp_pkg::BYTE_W-1:0]    midi_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           result_kind,
    output logic [1:0]                     byte_count,
    output logic [mbsp_pkg::BYTE_W-1:0]    first_byte,
    output logic [mbsp_pkg::BYTE_W-1:0]    second_byte,
    output logic [mbsp_pkg::BYTE_W-1:0]    third_byte,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import mbsp_pkg::*;

    beat_t   beat;
    logic    advance;
    logic    can_advance;
    logic    res_valid;
    result_t res;

    assign cfg_ready = 1'b1;

    mbsp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .midi_byte   (midi_byte),
        .can_advance (can_advance),
        .beat        (beat),
        .advance     (advance)
    );

    mbsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat      (beat),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    mbsp_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_valid   (res_valid),
        .res         (res),
        .can_advance (can_advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .byte_count  (byte_count),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte)
    );

endmodule

### tb/midi_byte_stream_parser_core_test.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_core_test
// Self-checking bench for the midi byte stream parser. A directed table walks
// the extremes and corner cases of the parse, then runs of random messages,
// sysex streams, real-time bytes and noise go through under each handler
// setting. Every beat is scored field by field against the table's result or an in-bench parse
// model, with random idling on both sides of the byte and result channels.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mbsp_pkg::*;

    typedef struct {
        logic [1:0]        handlers;
        logic [BYTE_W-1:0] b;
        bit                typed;
        bit                hit;
        result_t           res;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     midi_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  result_kind;
    logic [1:0]            byte_count;
    logic [BYTE_W-1:0]     first_byte;
    logic [BYTE_W-1:0]     second_byte;
    logic [BYTE_W-1:0]     third_byte;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic                  cfg_data = 1'b0;

    mode_t                 mode = MODE_IDLE;
    logic [1:0]            held_n = '0;
    logic [BYTE_W-1:0]     held [0:2] = '{default: '0};
    logic                  rt_on = 1'b0;
    logic                  def_on = 1'b0;

    result_t               pending_msgs [$];
    stim_row_t             stim_rows [$];
    int                    mismatches = 0;
    int                    sent_beats = 0;
    bit                    quiet = 1'b0;

    midi_byte_stream_parser_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .midi_byte   (midi_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .byte_count  (byte_count),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int msg_len(input logic [BYTE_W-1:0] b);
        if (b < 8'hC0)
            return 3;
        if (b < 8'hE0)
            return 2;
        if (b < 8'hF0)
            return 3;
        case (b)
            ST_MTC_QFRAME, ST_SONG_SEL: return 2;
            ST_SONG_POS:                return 3;
            ST_TUNE_REQ:                return 1;
            default:                    return (b >= ST_RT_FIRST) ? 1 : 0;
        endcase
    endfunction

    function automatic bit route(input logic [1:0] n, input logic [BYTE_W-1:0] b0,
                                 input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                                 output result_t r);
        r = '0;
        if (n == 2'd1 && b0 >= ST_RT_FIRST && rt_on)
            r.kind = KIND_REALTIME;
        else if (def_on)
            r.kind = KIND_DEFAULT;
        else
            return 1'b0;
        r.count  = n;
        r.first  = b0;
        r.second = (n >= 2'd2) ? b1 : '0;
        r.third  = (n == 2'd3) ? b2 : '0;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t r);
        int len;
        r = '0;
        if (b >= ST_RT_FIRST)
            return route(2'd1, b, '0, '0, r);
        if (b[7])
        begin
            if (mode != MODE_SYSEX)
            begin
                held[0] = b;
                held_n  = 2'd1;
            end
            len = msg_len(b);
            if (len == 1)
            begin
                mode = MODE_IDLE;
                return route(2'd1, b, '0, '0, r);
            end
            if (len == 2)
            begin
                mode = MODE_TWO;
                return 1'b0;
            end
            if (len == 3)
            begin
                mode = MODE_THREE;
                return 1'b0;
            end
            if (b == ST_SYSEX_START)
            begin
                mode = MODE_SYSEX;
                return 1'b0;
            end
            if (b == ST_SYSEX_END)
            begin
                if (held_n > 2'd2)
                    held_n = 2'd2;
                held[held_n] = b;
                held_n = held_n + 2'd1;
                mode = MODE_IDLE;
                return route(held_n, held[0], held[1], held[2], r);
            end
            mode   = MODE_IDLE;
            held_n = 2'd0;
            return 1'b0;
        end
        if (mode == MODE_IDLE)
            return 1'b0;
        if (held_n > 2'd2)
            held_n = 2'd2;
        held[held_n] = b;
        held_n = held_n + 2'd1;
        if (held_n == 2'd3)
        begin
            if (mode != MODE_SYSEX)
                mode = MODE_IDLE;
            held_n = 2'd0;
            return route(2'd3, held[0], held[1], held[2], r);
        end
        if (held_n == 2'd2)
        begin
            if (mode == MODE_TWO)
            begin
                mode = MODE_IDLE;
                return route(2'd2, held[0], held[1], '0, r);
            end
            return 1'b0;
        end
        if (mode != MODE_SYSEX)
            mode = MODE_IDLE;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string field, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        $display("mismatch on %s: got %h, want %h at %0t ns", field, got, want, $time);
        mismatches++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, output bit hit, output result_t res);
        while (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        midi_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        hit = parse_byte(b, res);
        sent_beats++;
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        bit      hit;
        result_t res;
        send_byte(b, hit, res);
        if (hit)
            pending_msgs.push_back(res);
    endtask

    // real-time bytes may cut into any message
    task automatic feed(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 5)
            queue_byte(BYTE_W'($urandom_range(8'hFF, ST_RT_FIRST)));
        queue_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] data7();
        return BYTE_W'($urandom_range(8'h7F));
    endfunction

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_msgs.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_RT_ON)
            rt_on = val;
        else
            def_on = val;
    endtask

    task automatic set_handlers(input logic [1:0] h);
        settle();
        write_reg(CFG_RT_ON, h[1]);
        write_reg(CFG_DEF_ON, h[0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [1:0] h, input logic [BYTE_W-1:0] b);
        stim_row_t row;
        row = '{h, b, 1'b0, 1'b0, '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_none(input logic [1:0] h, input logic [BYTE_W-1:0] b);
        stim_row_t row;
        row = '{h, b, 1'b1, 1'b0, '0};
        stim_rows.push_back(row);
    endtask

    task automatic add_hit(input logic [1:0] h, input logic [BYTE_W-1:0] b, input kind_t k,
                           input logic [1:0] n, input logic [BYTE_W-1:0] b0,
                           input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2);
        stim_row_t row;
        row = '{h, b, 1'b1, 1'b1, '{k, n, b0, b1, b2}};
        stim_rows.push_back(row);
    endtask

    task automatic send_message();
        int                pick;
        int                n;
        logic [BYTE_W-1:0] st;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            st = BYTE_W'($urandom_range(8'hEF, 8'h80));
            feed(st);
            n = (st >= ST_PROG_CHANGE && st < ST_PITCH_BEND) ? 1 : 2;
            repeat (n) feed(data7());
        end
        else if (pick < 55)
        begin
            case ($urandom_range(3))
                0:       begin st = ST_MTC_QFRAME; n = 1; end
                1:       begin st = ST_SONG_POS;   n = 2; end
                2:       begin st = ST_SONG_SEL;   n = 1; end
                default: begin st = ST_TUNE_REQ;   n = 0; end
            endcase
            feed(st);
            repeat (n) feed(data7());
        end
        else if (pick < 75)
        begin
            feed(ST_SYSEX_START);
            n = $urandom_range(9);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(19) == 0)
                    feed(BYTE_W'($urandom_range(8'hF6, 8'h80)));
                else
                    feed(data7());
            end
            if ($urandom_range(9) != 0)
                feed(ST_SYSEX_END);
        end
        else if (pick < 82)
            feed(BYTE_W'($urandom_range(8'hFF, ST_RT_FIRST)));
        else if (pick < 92)
        begin
            // channel status with at most one data byte, often a cut-off message
            feed(BYTE_W'($urandom_range(8'hEF, 8'h80)));
            if ($urandom_range(1))
                feed(data7());
        end
        else
            feed(BYTE_W'($urandom_range(8'hFF)));
    endtask

    always @(posedge clk)
    begin : rx_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_msgs.size() == 0)
                report_mismatch("unexpected beat", first_byte, '0);
            else
            begin
                want = pending_msgs.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", BYTE_W'(result_kind), BYTE_W'(want.kind));
                if (byte_count !== want.count)
                    report_mismatch("byte_count", BYTE_W'(byte_count), BYTE_W'(want.count));
                if (first_byte !== want.first)
                    report_mismatch("first_byte", first_byte, want.first);
                if (second_byte !== want.second)
                    report_mismatch("second_byte", second_byte, want.second);
                if (third_byte !== want.third)
                    report_mismatch("third_byte", third_byte, want.third);
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < 24);
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        bit         hit;
        result_t    res;
        logic [1:0] phase_cfg [0:4];
        phase_cfg = '{2'b11, 2'b10, 2'b01, 2'b00, 2'b11};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // handlers off straight after reset
        add_none(2'b00, 8'hF8);
        add_none(2'b00, 8'h00);
        add_hit(2'b11, 8'hFF, KIND_REALTIME, 2'd1, 8'hFF, 8'h00, 8'h00);
        add_row(2'b11, 8'h90);
        add_row(2'b11, 8'h00);
        add_hit(2'b11, 8'h7F, KIND_DEFAULT, 2'd3, 8'h90, 8'h00, 8'h7F);
        add_row(2'b11, 8'hDF);
        add_hit(2'b11, 8'h7F, KIND_DEFAULT, 2'd2, 8'hDF, 8'h7F, 8'h00);
        add_hit(2'b11, ST_TUNE_REQ, KIND_DEFAULT, 2'd1, ST_TUNE_REQ, 8'h00, 8'h00);
        add_none(2'b11, 8'hF4);
        add_row(2'b11, ST_SYSEX_START);
        add_row(2'b11, 8'h01);
        add_row(2'b11, 8'h02);
        // status inside sysex with nothing held, then a lone data byte
        add_row(2'b11, ST_PROG_CHANGE);
        add_none(2'b11, 8'h05);
        add_row(2'b11, ST_SYSEX_START);
        add_hit(2'b11, ST_RT_FIRST, KIND_REALTIME, 2'd1, ST_RT_FIRST, 8'h00, 8'h00);
        add_row(2'b11, ST_SYSEX_END);
        add_hit(2'b11, ST_SYSEX_END, KIND_DEFAULT, 2'd2, ST_SYSEX_END, ST_SYSEX_END, 8'h00);
        add_hit(2'b10, 8'hFE, KIND_REALTIME, 2'd1, 8'hFE, 8'h00, 8'h00);
        add_none(2'b10, ST_TUNE_REQ);
        add_hit(2'b01, ST_RT_FIRST, KIND_DEFAULT, 2'd1, ST_RT_FIRST, 8'h00, 8'h00);
        add_row(2'b01, ST_MTC_QFRAME);
        add_row(2'b01, 8'h7F);
        add_none(2'b01, 8'hF5);
        add_row(2'b01, 8'h80);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].handlers != {rt_on, def_on})
                set_handlers(stim_rows[i].handlers);
            send_byte(stim_rows[i].b, hit, res);
            if (stim_rows[i].typed)
            begin
                if (stim_rows[i].hit)
                    pending_msgs.push_back(stim_rows[i].res);
            end
            else if (hit)
                pending_msgs.push_back(res);
        end

        for (int p = 0; p < 5; p++)
        begin
            set_handlers(phase_cfg[p]);
            // one phase runs with no idling on either side
            quiet = (p == 2);
            while (sent_beats < 26 + 375 * (p + 1))
                send_message();
            quiet = 1'b0;
        end

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
